// ===== src/box_blur_3x3_unit_defines.svh =====
// ----------------------------------------------------------------------------
// box_blur_3x3_unit_defines.svh
// Assertion macros used by the checker of the box blur unit.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_UNIT_DEFINES_SVH
`define BOX_BLUR_3X3_UNIT_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define BB3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define BB3_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/bb3_pkg.sv =====
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared constants and types of the 3x3 box blur unit.
// ----------------------------------------------------------------------------
package bb3_pkg;

  // Image geometry limits.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  // Field widths.
  localparam int PIX_W  = 8;
  localparam int ROW_W  = 12;
  localparam int COL_W  = 10;
  localparam int WID_W  = 11;
  localparam int HGT_W  = 13;
  localparam int CFG_W  = 13;
  localparam int CFG_IDX_W = 1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  // Line RAM: one entry per column, holding the two previous rows.
  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int LINE_W = 2 * PIX_W;

  // Arithmetic widths: a column sum of three pixels and the sum of nine.
  localparam int CSUM_W = PIX_W + 2;
  localparam int SUM_W  = PIX_W + 4;

  // Division by nine as multiplication by ceil(2^16 / 9); exact for sums below 32768.
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 16;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << RECIP_SHIFT) + 8) / 9);

  // Output queue.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Stream data widths.
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;

  // Per-item tag that travels with a pixel through the pipeline.
  typedef struct packed {
    logic             emit;
    logic             last;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } meta_t;

  // One finished result as stored in the output queue.
  typedef struct packed {
    logic             last;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [PIX_W-1:0] blur;
  } out_item_t;

endpackage

// ===== src/bb3_line_ram.sv =====
// ----------------------------------------------------------------------------
// bb3_line_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bb3_line_ram #(
  parameter int DATA_W = 16,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/bb3_window.sv =====
// ----------------------------------------------------------------------------
// bb3_window
// Line RAM write-back, 3x3 window of column sums and the sum of nine.
// ----------------------------------------------------------------------------
module bb3_window import bb3_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clear,
  input  logic              in_valid,
  input  meta_t             in_meta,
  input  logic [ADDR_W-1:0] in_addr,
  input  logic [PIX_W-1:0]  in_pixel,
  input  logic [LINE_W-1:0] rd_data,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [LINE_W-1:0] wr_data,
  output logic              mid_valid,
  output logic              out_valid,
  output meta_t             out_meta,
  output logic [SUM_W-1:0]  out_sum
);

  logic [PIX_W-1:0]  up1;
  logic [PIX_W-1:0]  up2;
  logic [CSUM_W-1:0] col_sum;
  logic [CSUM_W-1:0] cs0_r, cs1_r, cs2_r;
  logic              v2_r;
  meta_t             meta2_r;
  logic              v3_r;
  meta_t             meta3_r;
  logic [SUM_W-1:0]  sum_r;

  // Entry layout: low byte is row r-1, high byte is row r-2.
  assign up1 = rd_data[PIX_W-1:0];
  assign up2 = rd_data[LINE_W-1:PIX_W];

  // Read-modify-write: the old r-1 byte moves up, the new pixel becomes r-1.
  assign wr_en   = in_valid;
  assign wr_addr = in_addr;
  assign wr_data = {up1, in_pixel};

  assign col_sum = CSUM_W'(up2) + CSUM_W'(up1) + CSUM_W'(in_pixel);

  // Window shift: the newest column sum enters on the right.
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      cs0_r <= '0;
      cs1_r <= '0;
      cs2_r <= '0;
    end else if (in_valid) begin
      cs0_r <= cs1_r;
      cs1_r <= cs2_r;
      cs2_r <= col_sum;
    end
  end

  // Stage valids; only interior positions travel on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v2_r <= in_valid && in_meta.emit;
      v3_r <= v2_r;
    end
  end

  // The window is complete in the cycle after the shift; add its three columns.
  always_ff @(posedge clk) begin
    if (in_valid) begin
      meta2_r <= in_meta;
    end
    if (v2_r) begin
      meta3_r <= meta2_r;
      sum_r   <= SUM_W'(cs0_r) + SUM_W'(cs1_r) + SUM_W'(cs2_r);
    end
  end

  assign mid_valid = v2_r;
  assign out_valid = v3_r;
  assign out_meta  = meta3_r;
  assign out_sum   = sum_r;

endmodule

// ===== src/bb3_div9.sv =====
// ----------------------------------------------------------------------------
// bb3_div9
// Truncating division of the window sum by nine through a reciprocal.
// ----------------------------------------------------------------------------
module bb3_div9 import bb3_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  meta_t            in_meta,
  input  logic [SUM_W-1:0] in_sum,
  output logic             out_valid,
  output meta_t            out_meta,
  output logic [PIX_W-1:0] out_blur
);

  logic [SUM_W+RECIP_W-1:0] prod;
  logic                     v_r;
  meta_t                    meta_r;
  logic [PIX_W-1:0]         blur_r;

  // floor(sum * RECIP / 2^16) equals floor(sum / 9) over the whole sum range.
  assign prod = (SUM_W+RECIP_W)'(in_sum) * (SUM_W+RECIP_W)'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      meta_r <= in_meta;
      blur_r <= prod[RECIP_SHIFT +: PIX_W];
    end
  end

  assign out_valid = v_r;
  assign out_meta  = meta_r;
  assign out_blur  = blur_r;

endmodule

// ===== src/bb3_out_fifo.sv =====
// ----------------------------------------------------------------------------
// bb3_out_fifo
// Small output queue that decouples the pipeline from the result consumer.
// ----------------------------------------------------------------------------
module bb3_out_fifo import bb3_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  out_item_t        push_item,
  input  logic             pop_ready,
  output logic             pop_valid,
  output out_item_t        pop_item,
  output logic [CNT_W-1:0] count
);

  out_item_t          buf_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               pop;

  assign pop_valid = (count_r != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_item  = buf_q[rd_ptr_r];
  assign count     = count_r;

  // Pointers and fill level. The producer never pushes into a full queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      buf_q[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== src/box_blur_3x3_unit.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_unit
// 3x3 mean filter over a raster stream of 8-bit grey pixels.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one per cycle sustained unless the output
// stalls: each pixel makes one read and one write of the line RAM (one 16-bit
// entry per column holding the two previous rows) on separate ports, hence one
// pixel per clock. For the pixel at (r,c) with r>=2 and c>=2 the unit emits
// floor(sum of the 3x3 neighborhood / 9) for the center (r-1,c-1) after the
// RAM read, window shift, sum, division and output queue; borders produce no
// output. The line RAM needs no clearing pass: the first two rows of a frame
// write it before a read is used. Writing image_width or image_height restarts
// the frame; write them only while the unit is idle.
// ----------------------------------------------------------------------------
module box_blur_3x3_unit import bb3_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input stream. in_tdata: [7:0] pixel.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // Result stream. out_tdata: [7:0] blurred, [19:8] out_row, [29:20] out_col,
  // [31:30] zero. out_tlast: last_of_frame.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  // Configuration write port.
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata
);

  logic [WID_W-1:0]  img_w_r;
  logic [HGT_W-1:0]  img_h_r;
  logic [WID_W-1:0]  w_use;
  logic [HGT_W-1:0]  h_use;
  logic [ROW_W-1:0]  row_r;
  logic [COL_W-1:0]  col_r;
  logic              col_last;
  logic              row_last;
  logic              accept;
  meta_t             meta0;
  logic              v1_r;
  meta_t             meta1_r;
  logic [ADDR_W-1:0] addr1_r;
  logic [PIX_W-1:0]  pix1_r;
  logic [LINE_W-1:0] rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [LINE_W-1:0] wr_data;
  logic              win_mid_valid;
  logic              win_valid;
  meta_t             win_meta;
  logic [SUM_W-1:0]  win_sum;
  logic              div_valid;
  meta_t             div_meta;
  logic [PIX_W-1:0]  div_blur;
  out_item_t         push_item;
  out_item_t         pop_item;
  logic [CNT_W-1:0]  fifo_count;
  logic [CNT_W:0]    pending;

  // Configuration registers; any write restarts the frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= WID_W'(MAX_WIDTH);
      img_h_r <= HGT_W'(MAX_HEIGHT);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  img_w_r <= cfg_wdata[WID_W-1:0];
        CFG_IMAGE_HEIGHT: img_h_r <= cfg_wdata[HGT_W-1:0];
      endcase
    end
  end

  // Clamp the geometry in use to the supported range.
  always_comb begin
    if (img_w_r < WID_W'(3)) begin
      w_use = WID_W'(3);
    end else if (img_w_r > WID_W'(MAX_WIDTH)) begin
      w_use = WID_W'(MAX_WIDTH);
    end else begin
      w_use = img_w_r;
    end
    if (img_h_r < HGT_W'(3)) begin
      h_use = HGT_W'(3);
    end else if (img_h_r > HGT_W'(MAX_HEIGHT)) begin
      h_use = HGT_W'(MAX_HEIGHT);
    end else begin
      h_use = img_h_r;
    end
  end

  // Every in-flight item ends up in the queue, so count it as taken space.
  assign pending   = (CNT_W+1)'(fifo_count) + (CNT_W+1)'(v1_r) + (CNT_W+1)'(win_mid_valid)
                   + (CNT_W+1)'(win_valid) + (CNT_W+1)'(div_valid);
  assign in_tready = pending < (CNT_W+1)'(FIFO_DEPTH);
  assign accept    = in_tvalid && in_tready;

  // Position decode for the arriving pixel.
  assign col_last   = (WID_W'(col_r) + WID_W'(1)) == w_use;
  assign row_last   = (HGT_W'(row_r) + HGT_W'(1)) == h_use;
  assign meta0.emit = (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2));
  assign meta0.last = row_last && col_last;
  assign meta0.row  = row_r - ROW_W'(1);
  assign meta0.col  = col_r - COL_W'(1);

  // Raster position counters.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      row_r <= '0;
      col_r <= '0;
    end else if (accept) begin
      if (col_last) begin
        col_r <= '0;
        row_r <= row_last ? '0 : row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  // First stage: the line RAM read is in flight.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      meta1_r <= meta0;
      addr1_r <= col_r[ADDR_W-1:0];
      pix1_r  <= in_tdata[PIX_W-1:0];
    end
  end

  bb3_line_ram #(
    .DATA_W (LINE_W),
    .ADDR_W (ADDR_W)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (col_r[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  bb3_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (cfg_we),
    .in_valid  (v1_r),
    .in_meta   (meta1_r),
    .in_addr   (addr1_r),
    .in_pixel  (pix1_r),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .mid_valid (win_mid_valid),
    .out_valid (win_valid),
    .out_meta  (win_meta),
    .out_sum   (win_sum)
  );

  bb3_div9 u_div9 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (win_valid),
    .in_meta   (win_meta),
    .in_sum    (win_sum),
    .out_valid (div_valid),
    .out_meta  (div_meta),
    .out_blur  (div_blur)
  );

  // Result item into the output queue.
  assign push_item.last = div_meta.last;
  assign push_item.col  = div_meta.col;
  assign push_item.row  = div_meta.row;
  assign push_item.blur = div_blur;

  bb3_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (div_valid),
    .push_item (push_item),
    .pop_ready (out_tready),
    .pop_valid (out_tvalid),
    .pop_item  (pop_item),
    .count     (fifo_count)
  );

  // Output packing.
  assign out_tdata = {(OUT_TDATA_W-PIX_W-ROW_W-COL_W)'(0), pop_item.col, pop_item.row,
                      pop_item.blur};
  assign out_tlast = pop_item.last;

endmodule

// ===== src/bb3_checker.sv =====
// ----------------------------------------------------------------------------
// bb3_checker
// Port-level checks of the box blur unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "box_blur_3x3_unit_defines.svh"

module bb3_checker import bb3_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  // A result is offered but not taken this cycle.
  logic stalled;
  assign stalled = out_tvalid && !out_tready;

  // A stalled result stays offered.
  `BB3_ASSERT(a_out_valid_hold, stalled |=> out_tvalid, "out_tvalid dropped while stalled")

  // A stalled result keeps its payload.
  `BB3_ASSERT(a_data_hold, stalled |=> $stable({out_tlast, out_tdata}), "payload changed")

  // Reset empties the result queue and frees the input side.
  `BB3_ASSERT_RST(a_reset_empty, !rst_n |=> !out_tvalid && in_tready, "queue not empty after reset")

endmodule

bind box_blur_3x3_unit bb3_checker u_bb3_checker (.*);

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 3x3 box blur unit. A scoreboard class runs its
// own line stores, window and raster counters on every pixel transfer and
// queues the expected interior results. Each result transfer is checked
// field by field against the oldest entry. The run covers the smallest frame,
// clamped and masked register values, restarts in the middle of a frame, a
// wider frame that runs into the next one and a narrow frame under the
// clamped tallest height, under random stalls on both streams and without stalls.
// ----------------------------------------------------------------------------
module testbench;
  import bb3_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Quiet cycles before a register write and after the last result.
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_CYCLES  = 20;

  // Geometry of the directed wide and tall frames.
  localparam int WIDE_COLS = 110;
  localparam int TALL_ROWS = 40;

  // Pixel mixes for the random frames.
  typedef enum int {PIX_UNIFORM, PIX_EXTREME, PIX_BRIGHT, PIX_DARK} pixel_mix_t;

  // One expected interior result.
  typedef struct packed {
    logic [PIX_W-1:0] blurred;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } blur_result_t;

  // Tracks the raster position and window contents, and checks each result.
  class blur_scoreboard;
    logic [WID_W-1:0] width_reg;
    logic [HGT_W-1:0] height_reg;
    logic [PIX_W-1:0] row_minus1 [MAX_WIDTH];
    logic [PIX_W-1:0] row_minus2 [MAX_WIDTH];
    logic [PIX_W-1:0] win [3][3];
    int unsigned      row_pos;
    int unsigned      col_pos;
    blur_result_t     pending_blurs [$];
    int unsigned      errors;

    function new();
      width_reg  = WID_W'(MAX_WIDTH);
      height_reg = HGT_W'(MAX_HEIGHT);
      foreach (row_minus1[i]) begin
        row_minus1[i] = '0;
        row_minus2[i] = '0;
      end
      errors = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      row_pos = 0;
      col_pos = 0;
      foreach (win[i, j]) win[i][j] = '0;
    endfunction

    function int unsigned pending();
      return pending_blurs.size();
    endfunction

    // A register write takes effect at once and restarts the frame.
    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_IMAGE_WIDTH) begin
        width_reg = val[WID_W-1:0];
      end else begin
        height_reg = val[HGT_W-1:0];
      end
      restart_frame();
    endfunction

    // Shift the window by one pixel and queue a result for interior centers.
    function void note_pixel(logic [PIX_W-1:0] px);
      int unsigned  w;
      int unsigned  h;
      int unsigned  sum;
      logic [PIX_W-1:0] above1;
      logic [PIX_W-1:0] above2;
      blur_result_t res;
      w = (width_reg < 3) ? 3 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
      h = (height_reg < 3) ? 3 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
      above1 = row_minus1[col_pos];
      above2 = row_minus2[col_pos];
      for (int k = 0; k < 3; k++) begin
        win[k][0] = win[k][1];
        win[k][1] = win[k][2];
      end
      win[0][2] = above2;
      win[1][2] = above1;
      win[2][2] = px;
      row_minus2[col_pos] = above1;
      row_minus1[col_pos] = px;

      if (row_pos >= 2 && col_pos >= 2) begin
        sum = 0;
        foreach (win[i, j]) sum += win[i][j];
        res.blurred = PIX_W'(sum / 9);
        res.row     = ROW_W'(row_pos - 1);
        res.col     = COL_W'(col_pos - 1);
        res.last    = (row_pos == h - 1) && (col_pos == w - 1);
        pending_blurs.push_back(res);
      end

      // Advance the raster position, wrapping at the end of the frame.
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= h) row_pos = 0;
      end
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] data, logic tlast);
      blur_result_t want;
      if (pending_blurs.size() == 0) begin
        report($sformatf("result %h last %b with none expected", data, tlast));
        return;
      end
      want = pending_blurs.pop_front();
      if (data[PIX_W-1:0] !== want.blurred)
        report($sformatf("blurred %0d, expected %0d at (%0d,%0d)",
                         data[PIX_W-1:0], want.blurred, want.row, want.col));
      if (data[PIX_W +: ROW_W] !== want.row)
        report($sformatf("row %0d, expected %0d", data[PIX_W +: ROW_W], want.row));
      if (data[PIX_W+ROW_W +: COL_W] !== want.col)
        report($sformatf("col %0d, expected %0d", data[PIX_W+ROW_W +: COL_W], want.col));
      if (data[OUT_TDATA_W-1:PIX_W+ROW_W+COL_W] !== '0)
        report($sformatf("padding bits not zero in %h", data));
      if (tlast !== want.last)
        report($sformatf("last %b, expected %b at (%0d,%0d)",
                         tlast, want.last, want.row, want.col));
    endtask
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_W-1:0]       cfg_wdata  = '0;

  // Stall rates of the two streams, in percent.
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;

  blur_scoreboard sb;

  box_blur_3x3_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Random back-pressure on the result stream.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Check every result transfer.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  function automatic logic [PIX_W-1:0] pick_pixel(pixel_mix_t mix);
    case (mix)
      PIX_EXTREME: return $urandom_range(1) ? 8'hFF : 8'h00;
      PIX_BRIGHT:  return 8'hF0 | PIX_W'($urandom_range(15));
      PIX_DARK:    return PIX_W'($urandom_range(15));
      default:     return PIX_W'($urandom_range(255));
    endcase
  endfunction

  // Offer one pixel, with random gaps, and hold it until the transfer.
  task send_pixel(input logic [PIX_W-1:0] px);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(px);
  endtask

  // Stop sending until every queued result has come out.
  task hold_until_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Registers are written only once the unit has gone quiet.
  task program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.apply_reg(idx, val);
    cfg_we <= 1'b0;
  endtask

  task send_frame(input int unsigned count, input pixel_mix_t mix);
    for (int unsigned i = 0; i < count; i++) send_pixel(pick_pixel(mix));
  endtask

  // Small random frames, often cut short by the next register write.
  task run_random(input int unsigned target);
    int unsigned sent;
    int unsigned count;
    int unsigned which;
    logic [CFG_W-1:0] wval;
    logic [CFG_W-1:0] hval;
    pixel_mix_t mix;
    sent = 0;
    while (sent < target) begin
      case ($urandom_range(9))
        0:       wval = CFG_W'($urandom_range(2));
        1:       wval = CFG_W'(($urandom_range(1, 3) << WID_W) | $urandom_range(3, 16));
        default: wval = CFG_W'($urandom_range(3, 24));
      endcase
      case ($urandom_range(9))
        0:       hval = CFG_W'($urandom_range(2));
        1:       hval = CFG_W'($urandom_range(11, 8191));
        default: hval = CFG_W'($urandom_range(3, 10));
      endcase
      which = $urandom_range(2);
      if (which != 1) program_reg(CFG_IMAGE_WIDTH, wval);
      if (which != 0) program_reg(CFG_IMAGE_HEIGHT, hval);

      mix   = ($urandom_range(2) != 0) ? PIX_UNIFORM : pixel_mix_t'($urandom_range(3));
      count = $urandom_range(10, 120);
      for (int unsigned i = 0; i < count; i++) begin
        if ($urandom_range(149) == 0) hold_until_drained();
        send_pixel(pick_pixel(mix));
      end
      sent += count;
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender idles lightly, receiver heavily.
    send_idle = 16;
    recv_idle = 56;

    // Smallest frame, bright then saturated white, then all black with masked and clamped values.
    program_reg(CFG_IMAGE_HEIGHT, 3);
    program_reg(CFG_IMAGE_WIDTH, 3);
    send_frame(9, PIX_BRIGHT);
    for (int i = 0; i < 9; i++) send_pixel(8'hFF);
    program_reg(CFG_IMAGE_WIDTH, 13'h1001);
    program_reg(CFG_IMAGE_HEIGHT, 0);
    for (int i = 0; i < 9; i++) send_pixel(8'h00);

    run_random(400);

    // Receiver idles lightly, sender heavily.
    send_idle = 56;
    recv_idle = 16;
    run_random(400);

    // Wider frame, running a few pixels into the next frame.
    program_reg(CFG_IMAGE_WIDTH, WIDE_COLS);
    program_reg(CFG_IMAGE_HEIGHT, 3);
    send_frame(3 * WIDE_COLS + $urandom_range(1, 5), PIX_UNIFORM);

    // No idling on either side.
    send_idle = 0;
    recv_idle = 0;
    run_random(400);

    // Narrowest width with the height clamped to the tallest frame.
    program_reg(CFG_IMAGE_WIDTH, 3);
    program_reg(CFG_IMAGE_HEIGHT, 13'h1FFF);
    send_frame(3 * TALL_ROWS, PIX_UNIFORM);

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));

    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hard stop in case the unit hangs.
  initial begin
    #5_000_000;
    sb.report($sformatf("timeout with %0d results outstanding", sb.pending()));
    $display("== FAIL ==");
    $finish;
  end

endmodule
